// File: rtl/pa_pkg.sv
// Shared types and codes for the primitive assembly block.
package pa_pkg;

	localparam logic [1:0] CMD_CONT  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_SCOPE = 2'd2;

	localparam logic [2:0] TOPO_QUADS   = 3'd0;
	localparam logic [2:0] TOPO_QSTRIP  = 3'd1;
	localparam logic [2:0] TOPO_TRIS    = 3'd2;
	localparam logic [2:0] TOPO_TSTRIP  = 3'd3;
	localparam logic [2:0] TOPO_FAN     = 3'd4;
	localparam logic [2:0] TOPO_RESET   = TOPO_TRIS;

	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_TRI    = 1'b1;

	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] tex_u;
		logic [31:0] tex_v;
		logic [31:0] color;
	} vertex_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} tri_t;

	// One burst of results: nv vertex records, then nt triangles.
	typedef struct packed {
		vertex_t [3:0] verts;
		tri_t [1:0]    tris;
		logic [2:0]    nv;
		logic [1:0]    nt;
	} job_t;

endpackage

// File: rtl/pa_front.sv
// Front end: takes input beats, tracks strip state and builds result jobs.
module pa_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [2:0]      topology,
	input  logic            in_fire,
	input  logic [1:0]      command,
	input  pa_pkg::vertex_t cur,
	output logic            push,
	output pa_pkg::job_t    job
);
	import pa_pkg::*;

	logic [31:0] vcnt_q;
	logic [2:0]  count_q;
	logic [31:0] base_q;
	vertex_t     pend_q [3];

	logic        is_vert;
	logic [2:0]  k;
	logic [2:0]  nx;
	logic [31:0] b;
	logic [31:0] base_nx;

	function automatic logic [2:0] advance(input logic [2:0] v);
		logic [2:0] n;
		n = v + 3'd1;
		if (n >= 3'd5)
			n = 3'd3;
		return n;
	endfunction

	always_comb begin
		is_vert = (command == CMD_CONT || command == CMD_START) && topology <= TOPO_FAN;
		k       = (command == CMD_START) ? 3'd0 : count_q;
		b       = vcnt_q;
		nx      = k;
		base_nx = base_q;
		job     = '0;
		unique case (topology)
			TOPO_QUADS: begin
				if (k >= 3'd3) begin
					job.verts = {cur, pend_q[2], pend_q[1], pend_q[0]};
					job.nv = 3'd4;
					job.nt = 2'd2;
					job.tris[0] = '{b, b + 32'd1, b + 32'd2};
					job.tris[1] = '{b, b + 32'd2, b + 32'd3};
					nx = 3'd0;
				end else begin
					nx = k + 3'd1;
				end
			end
			TOPO_QSTRIP: begin
				if (k >= 3'd3 && k[0]) begin
					job.verts = {cur, pend_q[2], pend_q[1], pend_q[0]};
					job.nv = 3'd4;
					job.nt = 2'd2;
					job.tris[0] = '{b, b + 32'd1, b + 32'd3};
					job.tris[1] = '{b, b + 32'd3, b + 32'd2};
				end
				nx = advance(k);
			end
			TOPO_TRIS: begin
				if (k >= 3'd2) begin
					job.verts = {160'd0, cur, pend_q[2], pend_q[1]};
					job.nv = 3'd3;
					job.nt = 2'd1;
					job.tris[0] = '{b, b + 32'd1, b + 32'd2};
					nx = 3'd0;
				end else begin
					nx = k + 3'd1;
				end
			end
			TOPO_TSTRIP, TOPO_FAN: begin
				if (k == 3'd2) begin
					job.verts = {160'd0, cur, pend_q[2], pend_q[1]};
					job.nv = 3'd3;
					job.nt = 2'd1;
					job.tris[0] = '{b, b + 32'd1, b + 32'd2};
					if (topology == TOPO_FAN)
						base_nx = b;
				end else if (k > 3'd2) begin
					job.verts[0] = cur;
					job.nv = 3'd1;
					job.nt = 2'd1;
					if (topology == TOPO_FAN)
						job.tris[0] = '{base_q, b - 32'd1, b};
					else if (k[0])
						job.tris[0] = '{b - 32'd1, b - 32'd2, b};
					else
						job.tris[0] = '{b - 32'd2, b - 32'd1, b};
				end
				nx = advance(k);
			end
			default: begin
				nx = count_q;
			end
		endcase
		push = in_fire && is_vert && job.nt != 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q  <= '0;
			count_q <= '0;
			base_q  <= '0;
		end else if (in_fire) begin
			if (command == CMD_SCOPE) begin
				vcnt_q  <= '0;
				count_q <= '0;
				base_q  <= '0;
			end else if (is_vert) begin
				vcnt_q  <= vcnt_q + 32'(job.nv);
				count_q <= nx;
				base_q  <= base_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && is_vert) begin
			pend_q[0] <= pend_q[1];
			pend_q[1] <= pend_q[2];
			pend_q[2] <= cur;
		end
	end

endmodule

// File: rtl/pa_queue.sv
// Two-entry job queue between front and back end.
module pa_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  pa_pkg::job_t wr_job,
	input  logic         pop,
	output logic         full,
	output logic         not_empty,
	output pa_pkg::job_t rd_job
);
	import pa_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	job_t             mem_q [QDEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;

	assign full      = count_q == (PW+1)'(QDEPTH);
	assign not_empty = count_q != '0;
	assign rd_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + (PW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (PW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_job;
	end

endmodule

// File: rtl/pa_back.sv
// Back end: walks the head job and emits one result beat per cycle unless stalled.
module pa_back (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         job_valid,
	input  pa_pkg::job_t job,
	output logic         pop,
	output logic         out_valid,
	input  logic         out_stall,
	output logic         kind,
	output logic [31:0]  out_pos_x,
	output logic [31:0]  out_pos_y,
	output logic [31:0]  out_tex_u,
	output logic [31:0]  out_tex_v,
	output logic [31:0]  out_color,
	output logic [31:0]  index_a,
	output logic [31:0]  index_b,
	output logic [31:0]  index_c,
	output logic         last_of_run
);
	import pa_pkg::*;

	logic [2:0] step_q;
	logic       valid_q;
	logic       take;
	logic [2:0] total;
	logic [2:0] tsel;
	logic       is_tri;
	logic       last;
	vertex_t    v_sel;
	tri_t       t_sel;

	always_comb begin
		take   = job_valid && (!valid_q || !out_stall);
		total  = job.nv + 3'(job.nt);
		tsel   = step_q - job.nv;
		is_tri = step_q >= job.nv;
		last   = step_q == total - 3'd1;
		v_sel  = is_tri ? '0 : job.verts[step_q[1:0]];
		t_sel  = is_tri ? job.tris[tsel[0]] : '0;
		pop    = take && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= '0;
		end else begin
			if (take)
				valid_q <= 1'b1;
			else if (!out_stall)
				valid_q <= 1'b0;
			if (take)
				step_q <= last ? 3'd0 : step_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind        <= is_tri ? KIND_TRI : KIND_VERTEX;
			out_pos_x   <= v_sel.pos_x;
			out_pos_y   <= v_sel.pos_y;
			out_tex_u   <= v_sel.tex_u;
			out_tex_v   <= v_sel.tex_v;
			out_color   <= v_sel.color;
			index_a     <= t_sel.a;
			index_b     <= t_sel.b;
			index_c     <= t_sel.c;
			last_of_run <= last;
		end
	end

	assign out_valid = valid_q;

endmodule

// File: rtl/primitive_assembly.sv
// Top level of the primitive assembly block: topology register and front/queue/back.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | in_valid / in_stall   | command, pos_x, pos_y, tex_u, tex_v, color
//  output   | out_valid / out_stall | kind, out_* vertex words, index_a..c, last_of_run
//  config   | cfg_valid / cfg_ready | topology
//
// An input beat is taken every cycle while the two-entry job queue has room.
// The back end sends one result per cycle unless stalled; an item that causes
// n results holds the output until all are sent (quad strip: three per vertex).
// Reset clears counters, queue and output valid; topology returns to triangles.
// An output stall holds the output register; the queue absorbs up to two jobs.
module primitive_assembly (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  topology,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] tex_u,
	input  logic [31:0] tex_v,
	input  logic [31:0] color,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [31:0] out_pos_x,
	output logic [31:0] out_pos_y,
	output logic [31:0] out_tex_u,
	output logic [31:0] out_tex_v,
	output logic [31:0] out_color,
	output logic [31:0] index_a,
	output logic [31:0] index_b,
	output logic [31:0] index_c,
	output logic        last_of_run
);
	import pa_pkg::*;

	logic [2:0] topo_q;
	logic       in_fire;
	logic       push;
	logic       pop;
	logic       full;
	logic       not_empty;
	job_t       wr_job;
	job_t       rd_job;
	vertex_t    cur;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign in_fire   = in_valid && !full;
	assign cur       = '{pos_x, pos_y, tex_u, tex_v, color};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			topo_q <= TOPO_RESET;
		else if (cfg_valid && cfg_ready)
			topo_q <= topology;
	end

	pa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.topology (topo_q),
		.in_fire  (in_fire),
		.command  (command),
		.cur      (cur),
		.push     (push),
		.job      (wr_job)
	);

	pa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_job    (wr_job),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.rd_job    (rd_job)
	);

	pa_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (not_empty),
		.job         (rd_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.out_pos_x   (out_pos_x),
		.out_pos_y   (out_pos_y),
		.out_tex_u   (out_tex_u),
		.out_tex_v   (out_tex_v),
		.out_color   (out_color),
		.index_a     (index_a),
		.index_b     (index_b),
		.index_c     (index_c),
		.last_of_run (last_of_run)
	);

endmodule
